@@ rtl/core/icmp_echo_reply_checker_defines.svh @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker assertion macros
// Shared forms of the concurrent checks used in the checker top level.
// ----------------------------------------------------------------------------
`ifndef ICMP_ECHO_REPLY_CHECKER_DEFINES_SVH
`define ICMP_ECHO_REPLY_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ICERC_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ICERC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/icerc_pkg.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker package
// Constants, status codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package icerc_pkg;

  localparam int MAX_PACKET_BYTES = 1024;
  // A word index below these limits still has its low or high byte inside the packet.
  localparam int LO_LIMIT = (MAX_PACKET_BYTES + 1) / 2;
  localparam int HI_LIMIT = MAX_PACKET_BYTES / 2;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_NOT_REPLY = 3'd2;
  localparam logic [2:0] STATUS_ID        = 3'd3;
  localparam logic [2:0] STATUS_DUP       = 3'd4;
  localparam logic [2:0] STATUS_BAD_SUM   = 3'd5;

  localparam logic [1:0] REG_OWN_ID      = 2'd0;
  localparam logic [1:0] REG_ID_CHECK_ON = 2'd1;

  localparam logic [15:0] IDX_TYPE     = 16'd0;
  localparam logic [15:0] IDX_IDENT    = 16'd2;
  localparam logic [15:0] IDX_SEQ      = 16'd3;
  localparam logic [15:0] IDX_SEC_LO   = 16'd4;
  localparam logic [15:0] IDX_SEC_HI   = 16'd5;
  localparam logic [15:0] IDX_USEC_LO  = 16'd8;
  localparam logic [15:0] IDX_USEC_HI  = 16'd9;

  localparam logic [31:0]        MIN_RESET_US = 32'd10000000;
  localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;
  localparam logic [15:0]        SUM_GOOD     = 16'hffff;

  typedef struct packed {
    logic accept;    // a packet word is taken this cycle
    logic verdict;   // evaluate the checks on the captured packet
    logic mul;       // form the scaled seconds difference
    logic clamp;     // form and clamp the round trip
    logic square;    // square the round trip
    logic update;    // fold the round trip into the statistics
    logic load_out;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic ok;        // the verdict being evaluated is a good reply
  } stat_t;

endpackage

@@ rtl/core/icerc_if.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker channel interfaces
// Packet word channel in, result channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface icerc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic        last;
  logic        odd_byte;
  logic [31:0] recv_sec;
  logic [19:0] recv_usec;

  modport source (output valid, word, last, odd_byte, recv_sec, recv_usec, input ready);
  modport sink   (input valid, word, last, odd_byte, recv_sec, recv_usec, output ready);
endinterface

interface icerc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] sequence_res;
  logic [31:0] rtt_us;
  logic [31:0] min_rtt_us;
  logic [31:0] max_rtt_us;
  logic [47:0] rtt_sum_us;
  logic [63:0] rtt_square_sum;
  logic [31:0] good_count;

  modport source (output valid, status, sequence_res, rtt_us, min_rtt_us, max_rtt_us,
                  rtt_sum_us, rtt_square_sum, good_count, input ready);
  modport sink   (input valid, status, sequence_res, rtt_us, min_rtt_us, max_rtt_us,
                  rtt_sum_us, rtt_square_sum, good_count, output ready);
endinterface

@@ rtl/core/icmp_echo_reply_checker.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker
// Checks received echo replies and keeps round-trip time statistics.
// ----------------------------------------------------------------------------
// Packet words come in one beat per cycle while the input is ready, earlier
// byte in the low half, and the block folds the one's-complement checksum and
// captures type, identifier, sequence and the send timestamp as they pass. The
// beat marked last closes the packet and yields exactly one result beat with
// the verdict (short, not an echo reply, identifier mismatch, duplicate or old
// sequence, bad checksum, or ok), the round trip in microseconds for a good
// reply, and the running min, max, sum, sum of squares and count. After the
// last beat the input stays not ready through the verdict and, for a good
// reply, the round-trip steps (scale the seconds difference, add and clamp,
// square, update the statistics), which run one after another in the datapath,
// one register stage each. The result sits in an output register, so the next
// packet is taken while it waits; the block only holds off if a second result
// is ready before the first is taken. Configuration (own identifier,
// identifier check enable) is written through the plain write port while no
// packet is in flight, a rule for the user that the block does not enforce.
module icmp_echo_reply_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_index,
  input  logic [15:0]       cfg_wr_data,
  icerc_in_if.sink          in_ch,
  icerc_out_if.source       out_ch
);

  `include "icmp_echo_reply_checker_defines.svh"

  icerc_pkg::cmd_t  cmd;
  icerc_pkg::stat_t stat;

  // The controller owns the handshakes; the datapath owns all payload state.
  icerc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  icerc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_index   (cfg_wr_index),
    .cfg_wr_data    (cfg_wr_data),
    .word           (in_ch.word),
    .last           (in_ch.last),
    .odd_byte       (in_ch.odd_byte),
    .recv_sec       (in_ch.recv_sec),
    .recv_usec      (in_ch.recv_usec),
    .cmd            (cmd),
    .stat           (stat),
    .status         (out_ch.status),
    .sequence_res   (out_ch.sequence_res),
    .rtt_us         (out_ch.rtt_us),
    .min_rtt_us     (out_ch.min_rtt_us),
    .max_rtt_us     (out_ch.max_rtt_us),
    .rtt_sum_us     (out_ch.rtt_sum_us),
    .rtt_square_sum (out_ch.rtt_square_sum),
    .good_count     (out_ch.good_count)
  );

  // A rejected reply never reports a round trip.
  `ICERC_ASSERT_SAME(a_rtt_zero_unless_ok, clk, rst,
    out_ch.valid && (out_ch.status != icerc_pkg::STATUS_OK), out_ch.rtt_us == 32'd0,
    "nonzero round trip on a rejected reply")

  // Once any good reply has been counted, the minimum cannot exceed the maximum.
  `ICERC_ASSERT_SAME(a_min_le_max, clk, rst,
    out_ch.valid && (out_ch.good_count != 32'd0), out_ch.min_rtt_us <= out_ch.max_rtt_us,
    "minimum round trip above maximum")

  // Closing a packet makes the block busy for the verdict.
  `ICERC_ASSERT_NEXT(a_busy_after_last, clk, rst,
    in_ch.valid && in_ch.ready && in_ch.last, !in_ch.ready,
    "word taken during the verdict")

endmodule

@@ rtl/core/icerc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker controller
// Sequences word collection, the verdict, the round-trip steps and output.
// ----------------------------------------------------------------------------
module icerc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  input  logic             out_ready,
  input  icerc_pkg::stat_t stat,
  output logic             in_ready,
  output logic             out_valid,
  output icerc_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_VERDICT = 3'd1;
  localparam logic [2:0] ST_MUL     = 3'd2;
  localparam logic [2:0] ST_CLAMP   = 3'd3;
  localparam logic [2:0] ST_SQUARE  = 3'd4;
  localparam logic [2:0] ST_UPDATE  = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       load;

  assign in_ready = (state == ST_COLLECT);
  assign accept   = in_valid && in_ready;
  assign load     = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (accept && in_last) state_next = ST_VERDICT;
      ST_VERDICT: state_next = stat.ok ? ST_MUL : ST_DONE;
      ST_MUL:     state_next = ST_CLAMP;
      ST_CLAMP:   state_next = ST_SQUARE;
      ST_SQUARE:  state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_DONE;
      ST_DONE:    if (load) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.verdict  = (state == ST_VERDICT);
    cmd.mul      = (state == ST_MUL);
    cmd.clamp    = (state == ST_CLAMP);
    cmd.square   = (state == ST_SQUARE);
    cmd.update   = (state == ST_UPDATE);
    cmd.load_out = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/icerc_datapath.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker datapath
// Checksum fold, field capture, verdict, round-trip math and statistics.
// ----------------------------------------------------------------------------
module icerc_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_index,
  input  logic [15:0]      cfg_wr_data,
  input  logic [15:0]      word,
  input  logic             last,
  input  logic             odd_byte,
  input  logic [31:0]      recv_sec,
  input  logic [19:0]      recv_usec,
  input  icerc_pkg::cmd_t  cmd,
  output icerc_pkg::stat_t stat,
  output logic [2:0]       status,
  output logic [15:0]      sequence_res,
  output logic [31:0]      rtt_us,
  output logic [31:0]      min_rtt_us,
  output logic [31:0]      max_rtt_us,
  output logic [47:0]      rtt_sum_us,
  output logic [63:0]      rtt_square_sum,
  output logic [31:0]      good_count
);

  logic [15:0] own_id;
  logic        id_check_on;

  logic [15:0] word_index;
  logic [15:0] sum_acc;
  logic [7:0]  cap_type;
  logic [15:0] cap_ident;
  logic [15:0] cap_seq;
  logic [31:0] send_seconds;
  logic [31:0] send_micros;
  logic        seq_seen;
  logic [15:0] newest_seq;
  logic        short_q;
  logic        sum_ok_q;
  logic [31:0] rsec_q;
  logic [19:0] rusec_q;
  logic [2:0]  status_q;

  logic signed [52:0] prod_q;
  logic signed [32:0] du_q;
  logic [31:0]        rtt_q;
  logic [63:0]        sq_q;

  logic [31:0] min_store;
  logic [31:0] max_store;
  logic [47:0] sum_store;
  logic [63:0] square_store;
  logic [31:0] count_store;

  logic        odd_eff;
  logic [15:0] w;
  logic [16:0] s_raw;
  logic [15:0] sum_next;
  logic        short_next;
  logic [2:0]  status_v;
  logic signed [32:0] ds;
  logic signed [52:0] prod_next;
  logic signed [32:0] du_next;
  logic signed [53:0] d_full;
  logic [31:0] rtt_next;
  logic [48:0] sum_add;
  logic [64:0] sq_add;

  // Byte presence: the high byte of an odd final word and bytes past the cap read as zero.
  assign odd_eff = last && odd_byte;
  always_comb begin
    w = '0;
    if ({1'b0, word_index} < 17'(icerc_pkg::LO_LIMIT)) w[7:0] = word[7:0];
    if (({1'b0, word_index} < 17'(icerc_pkg::HI_LIMIT)) && !odd_eff) w[15:8] = word[15:8];
  end

  // One's-complement add with end-around carry.
  assign s_raw    = {1'b0, sum_acc} + {1'b0, w};
  assign sum_next = s_raw[15:0] + {15'b0, s_raw[16]};

  // Fewer than eight bytes: index below three, or index three with only its low byte.
  assign short_next = (word_index < 16'd3) || ((word_index == 16'd3) && odd_eff);

  always_comb begin
    if (short_q) begin
      status_v = icerc_pkg::STATUS_SHORT;
    end else if (cap_type != 8'd0) begin
      status_v = icerc_pkg::STATUS_NOT_REPLY;
    end else if (id_check_on && (cap_ident != own_id)) begin
      status_v = icerc_pkg::STATUS_ID;
    end else if (seq_seen && (cap_seq <= newest_seq)) begin
      status_v = icerc_pkg::STATUS_DUP;
    end else if (sum_ok_q) begin
      status_v = icerc_pkg::STATUS_OK;
    end else begin
      status_v = icerc_pkg::STATUS_BAD_SUM;
    end
  end
  assign stat.ok = (status_v == icerc_pkg::STATUS_OK);

  // Round trip = (rsec - ssec) * 1e6 + (rusec - susec), exact and signed.
  assign ds        = $signed({1'b0, rsec_q}) - $signed({1'b0, send_seconds});
  assign prod_next = 53'(ds) * 53'(icerc_pkg::USEC_PER_SEC);
  assign du_next   = $signed({13'b0, rusec_q}) - $signed({1'b0, send_micros});
  assign d_full    = 54'(prod_q) + 54'(du_q);

  always_comb begin
    if (d_full[53]) begin
      rtt_next = '0;
    end else if (d_full[52:32] != '0) begin
      rtt_next = '1;
    end else begin
      rtt_next = d_full[31:0];
    end
  end

  assign sum_add = {1'b0, sum_store} + {17'b0, rtt_q};
  assign sq_add  = {1'b0, square_store} + {1'b0, sq_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id       <= '0;
      id_check_on  <= 1'b0;
      word_index   <= '0;
      sum_acc      <= '0;
      cap_type     <= '0;
      cap_ident    <= '0;
      cap_seq      <= '0;
      send_seconds <= '0;
      send_micros  <= '0;
      seq_seen     <= 1'b0;
      newest_seq   <= '0;
      min_store    <= icerc_pkg::MIN_RESET_US;
      max_store    <= '0;
      sum_store    <= '0;
      square_store <= '0;
      count_store  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_wr_index)
          icerc_pkg::REG_OWN_ID:      own_id <= cfg_wr_data;
          icerc_pkg::REG_ID_CHECK_ON: id_check_on <= cfg_wr_data[0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        if (word_index == icerc_pkg::IDX_TYPE) begin
          cap_ident    <= '0;
          cap_seq      <= '0;
          send_seconds <= '0;
          send_micros  <= '0;
        end
        case (word_index)
          icerc_pkg::IDX_TYPE:    cap_type <= w[7:0];
          icerc_pkg::IDX_IDENT:   cap_ident <= w;
          icerc_pkg::IDX_SEQ:     cap_seq <= w;
          icerc_pkg::IDX_SEC_LO:  send_seconds[15:0] <= w;
          icerc_pkg::IDX_SEC_HI:  send_seconds[31:16] <= w;
          icerc_pkg::IDX_USEC_LO: send_micros[15:0] <= w;
          icerc_pkg::IDX_USEC_HI: send_micros[31:16] <= w;
          default: ;
        endcase
        if (last) begin
          word_index <= '0;
          sum_acc    <= '0;
        end else begin
          sum_acc <= sum_next;
          if (word_index != 16'hffff) word_index <= word_index + 16'd1;
        end
      end

      if (cmd.verdict) begin
        if ((status_v == icerc_pkg::STATUS_OK) || (status_v == icerc_pkg::STATUS_BAD_SUM)) begin
          newest_seq <= cap_seq;
          seq_seen   <= 1'b1;
        end
      end

      if (cmd.update) begin
        if (rtt_q < min_store) min_store <= rtt_q;
        if (rtt_q > max_store) max_store <= rtt_q;
        sum_store    <= sum_add[48] ? '1 : sum_add[47:0];
        square_store <= sq_add[64] ? '1 : sq_add[63:0];
        if (count_store != '1) count_store <= count_store + 32'd1;
      end
    end
  end

  // Payload and pipeline registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      short_q  <= short_next;
      sum_ok_q <= (sum_next == icerc_pkg::SUM_GOOD);
      rsec_q   <= recv_sec;
      rusec_q  <= recv_usec;
    end
    if (cmd.verdict) begin
      status_q <= status_v;
      rtt_q    <= '0;
    end
    if (cmd.mul) begin
      prod_q <= prod_next;
      du_q   <= du_next;
    end
    if (cmd.clamp) rtt_q <= rtt_next;
    if (cmd.square) sq_q <= {32'b0, rtt_q} * {32'b0, rtt_q};
    if (cmd.load_out) begin
      status         <= status_q;
      sequence_res   <= cap_seq;
      rtt_us         <= rtt_q;
      min_rtt_us     <= (count_store == '0) ? '0 : min_store;
      max_rtt_us     <= max_store;
      rtt_sum_us     <= sum_store;
      rtt_square_sum <= square_store;
      good_count     <= count_store;
    end
  end

endmodule

@@ tb/tb_icmp_echo_reply_checker.sv @@
// ----------------------------------------------------------------------------
// ICMP echo reply checker testbench
// Sends echo reply packets word by word, predicts every verdict and the running
// round-trip statistics, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_icmp_echo_reply_checker;
  timeunit 1ns;
  timeprecision 1ps;

  // Registers 2 and 3 do not exist; writes to them must leave the block alone.
  localparam logic [1:0]  REG_SPARE_A = 2'd2;
  localparam logic [1:0]  REG_SPARE_B = 2'd3;

  localparam logic [47:0] RTT_SUM_MAX   = '1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SHOWN_ERRORS  = 10;

  // One beat on the packet word channel.
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic        odd_byte;
    logic [31:0] recv_sec;
    logic [19:0] recv_usec;
  } pkt_beat_t;

  // One result beat, as the block is expected to present it.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] seq;
    logic [31:0] rtt;
    logic [31:0] min_rtt;
    logic [31:0] max_rtt;
    logic [47:0] rtt_sum;
    logic [63:0] rtt_sq_sum;
    logic [31:0] count;
  } echo_verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_index;
  logic [15:0] cfg_wr_data;

  icerc_in_if  in_ch ();
  icerc_out_if out_ch ();

  icmp_echo_reply_checker dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  always #1 clk = ~clk;

  // Verdicts still owed by the block, oldest first.
  echo_verdict_t pending_verdicts[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // The packet being assembled by the stimulus tasks.
  logic [15:0] pkt_words[$];
  bit          pkt_odd;

  // Shadow copy of the block's registers and state, kept by the predictor.
  logic [15:0] m_own_id;
  logic        m_id_check;
  logic [15:0] m_word_idx;
  logic [15:0] m_sum;
  logic [7:0]  m_type;
  logic [15:0] m_ident;
  logic [15:0] m_seq;
  logic [31:0] m_send_sec;
  logic [31:0] m_send_usec;
  logic        m_seq_seen;
  logic [15:0] m_newest_seq;
  logic [31:0] m_min;
  logic [31:0] m_max;
  logic [47:0] m_total;
  logic [63:0] m_sq_total;
  logic [31:0] m_count;

  // --------------------------------------------------------------------------
  // Predictor. Folds one accepted word into the shadow state; on the final
  // word of a packet it decides the verdict, updates the statistics and queues
  // the result the block owes.
  // --------------------------------------------------------------------------
  task automatic fold_beat(input pkt_beat_t b);
    int unsigned   lo_pos;
    int unsigned   nbytes;
    bit            odd;
    logic [15:0]   eff;
    logic [16:0]   s;
    logic [2:0]    st;
    logic [31:0]   rtt;
    longint        d;
    logic [63:0]   sq;
    echo_verdict_t v;

    odd    = b.last && b.odd_byte;
    lo_pos = 2 * m_word_idx;
    eff    = 16'h0000;
    rtt    = 32'h0;
    // Bytes past the packet size limit and the missing high byte of an
    // odd-length packet count as zero everywhere.
    if (lo_pos < icerc_pkg::MAX_PACKET_BYTES) eff[7:0] = b.word[7:0];
    if (lo_pos + 1 < icerc_pkg::MAX_PACKET_BYTES && !odd) eff[15:8] = b.word[15:8];

    // The first word of a packet wipes whatever the previous one left behind.
    if (m_word_idx == icerc_pkg::IDX_TYPE) begin
      m_type      = 8'h00;
      m_ident     = 16'h0000;
      m_seq       = 16'h0000;
      m_send_sec  = 32'h0;
      m_send_usec = 32'h0;
    end
    case (m_word_idx)
      icerc_pkg::IDX_TYPE:    m_type = eff[7:0];
      icerc_pkg::IDX_IDENT:   m_ident = eff;
      icerc_pkg::IDX_SEQ:     m_seq = eff;
      icerc_pkg::IDX_SEC_LO:  m_send_sec[15:0] = eff;
      icerc_pkg::IDX_SEC_HI:  m_send_sec[31:16] = eff;
      icerc_pkg::IDX_USEC_LO: m_send_usec[15:0] = eff;
      icerc_pkg::IDX_USEC_HI: m_send_usec[31:16] = eff;
      default: ;
    endcase

    // One's-complement add with the carry folded back in.
    s     = m_sum + eff;
    m_sum = s[15:0] + 16'(s[16]);

    if (!b.last) begin
      if (m_word_idx != 16'hffff) m_word_idx++;
    end else begin
      nbytes = 2 * (m_word_idx + 1) - (odd ? 1 : 0);
      if (nbytes > icerc_pkg::MAX_PACKET_BYTES) nbytes = icerc_pkg::MAX_PACKET_BYTES;

      if (nbytes < 8) begin
        st = icerc_pkg::STATUS_SHORT;
      end else if (m_type != 8'h00) begin
        st = icerc_pkg::STATUS_NOT_REPLY;
      end else if (m_id_check && m_ident != m_own_id) begin
        st = icerc_pkg::STATUS_ID;
      end else if (m_seq_seen && m_seq <= m_newest_seq) begin
        st = icerc_pkg::STATUS_DUP;
      end else begin
        // The sequence is recorded even when the checksum then fails.
        m_newest_seq = m_seq;
        m_seq_seen   = 1'b1;
        st = (m_sum == icerc_pkg::SUM_GOOD) ? icerc_pkg::STATUS_OK : icerc_pkg::STATUS_BAD_SUM;
      end

      if (st == icerc_pkg::STATUS_OK) begin
        // Plain signed differences, so a receive time before the send time
        // gives a negative round trip that clamps to zero.
        d = ($signed({32'h0, b.recv_sec}) - $signed({32'h0, m_send_sec}))
              * icerc_pkg::USEC_PER_SEC
            + ($signed({44'h0, b.recv_usec}) - $signed({32'h0, m_send_usec}));
        if (d < 0) begin
          rtt = 32'h0;
        end else if (d > 64'sh0000_0000_ffff_ffff) begin
          rtt = 32'hffff_ffff;
        end else begin
          rtt = d[31:0];
        end
        if (rtt < m_min) m_min = rtt;
        if (rtt > m_max) m_max = rtt;
        if (m_total > RTT_SUM_MAX - rtt) m_total = RTT_SUM_MAX;
        else m_total = m_total + rtt;
        sq = {32'h0, rtt} * {32'h0, rtt};
        if (m_sq_total > ~sq) m_sq_total = '1;
        else m_sq_total = m_sq_total + sq;
        if (m_count != 32'hffff_ffff) m_count++;
      end

      v.status     = st;
      v.seq        = m_seq;
      v.rtt        = rtt;
      v.min_rtt    = (m_count == 32'h0) ? 32'h0 : m_min;
      v.max_rtt    = m_max;
      v.rtt_sum    = m_total;
      v.rtt_sq_sum = m_sq_total;
      v.count      = m_count;
      pending_verdicts.push_back(v);

      m_word_idx = 16'h0000;
      m_sum      = 16'h0000;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side. The receiver stalls at the rate of the current phase; every
  // beat taken is held against the oldest verdict still owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      if (mismatch_count < SHOWN_ERRORS)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    echo_verdict_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatch_count < SHOWN_ERRORS)
          $display("result beat with no packet pending, status %0d", out_ch.status);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("sequence_res", 64'(want.seq), 64'(out_ch.sequence_res));
        check_field("rtt_us", 64'(want.rtt), 64'(out_ch.rtt_us));
        check_field("min_rtt_us", 64'(want.min_rtt), 64'(out_ch.min_rtt_us));
        check_field("max_rtt_us", 64'(want.max_rtt), 64'(out_ch.max_rtt_us));
        check_field("rtt_sum_us", 64'(want.rtt_sum), 64'(out_ch.rtt_sum_us));
        check_field("rtt_square_sum", want.rtt_sq_sum, out_ch.rtt_square_sum);
        check_field("good_count", 64'(want.count), 64'(out_ch.good_count));
      end
    end
  end

  // A hung handshake must not hang the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Packet side.
  // --------------------------------------------------------------------------

  // Offers one beat, idling first at the phase's rate, and hands it to the
  // predictor once the block takes it. Valid is left high on return so that
  // back-to-back beats need no second assignment in the same step.
  task automatic send_beat(input pkt_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.word      <= b.word;
    in_ch.last      <= b.last;
    in_ch.odd_byte  <= b.odd_byte;
    in_ch.recv_sec  <= b.recv_sec;
    in_ch.recv_usec <= b.recv_usec;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    fold_beat(b);
    beats_sent++;
  endtask

  // Sends the assembled packet. The receive time only matters on the last
  // beat; earlier beats and the odd flag of earlier beats carry noise.
  task automatic drive_packet(input logic [31:0] rsec, input logic [19:0] rusec);
    pkt_beat_t b;
    foreach (pkt_words[i]) begin
      b.word      = pkt_words[i];
      b.last      = (i == pkt_words.size() - 1);
      b.odd_byte  = b.last ? pkt_odd : 1'($urandom_range(1));
      b.recv_sec  = b.last ? rsec : 32'($urandom);
      b.recv_usec = b.last ? rusec : 20'($urandom_range(999999));
      send_beat(b);
    end
  endtask

  // Lays out an echo packet with random filler and a checksum word that makes
  // the folded sum come out right, given the bytes the block will really see.
  task automatic make_echo(input logic [7:0] typ, input logic [15:0] ident, seq,
                           input logic [31:0] ssec, susec, input int nwords, input bit odd);
    logic [15:0] acc;
    logic [15:0] w;
    logic [16:0] s;
    pkt_words.delete();
    pkt_odd = odd;
    for (int i = 0; i < nwords; i++) begin
      case (i)
        icerc_pkg::IDX_TYPE:    w = {8'($urandom), typ};
        icerc_pkg::IDX_IDENT:   w = ident;
        icerc_pkg::IDX_SEQ:     w = seq;
        icerc_pkg::IDX_SEC_LO:  w = ssec[15:0];
        icerc_pkg::IDX_SEC_HI:  w = ssec[31:16];
        icerc_pkg::IDX_USEC_LO: w = susec[15:0];
        icerc_pkg::IDX_USEC_HI: w = susec[31:16];
        default:                w = 16'($urandom);
      endcase
      if (i == 1) w = 16'h0000;
      pkt_words.push_back(w);
    end
    acc = 16'h0000;
    for (int i = 0; i < nwords; i++) begin
      w = pkt_words[i];
      if (2 * i >= icerc_pkg::MAX_PACKET_BYTES) w[7:0] = 8'h00;
      if (2 * i + 1 >= icerc_pkg::MAX_PACKET_BYTES || (odd && i == nwords - 1))
        w[15:8] = 8'h00;
      s   = acc + w;
      acc = s[15:0] + 16'(s[16]);
    end
    if (nwords > 1) pkt_words[1] = ~acc;
  endtask

  task automatic send_echo(input logic [7:0] typ, input logic [15:0] ident, seq,
                           input logic [31:0] ssec, susec, input int nwords, input bit odd,
                           input logic [31:0] rsec, input logic [19:0] rusec);
    make_echo(typ, ident, seq, ssec, susec, nwords, odd);
    drive_packet(rsec, rusec);
  endtask

  // Stops offering beats until every owed result has been taken, then lets
  // the block finish any round-trip steps still running.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= idx;
    cfg_wr_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == icerc_pkg::REG_OWN_ID) m_own_id = data;
    else if (idx == icerc_pkg::REG_ID_CHECK_ON) m_id_check = data[0];
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Every verdict but the identifier mismatch, with the reset configuration: identifier check off.
  task automatic test_verdicts();
    // A lone word and a seven-byte packet are both too short.
    send_echo(8'h00, 16'h0, 16'h0, 32'h0, 32'h0, 1, 1'b0, 32'h0, 20'h0);
    send_echo(8'h00, 16'h0, 16'h0, 32'h0, 32'h0, 4, 1'b1, 32'h0, 20'h0);
    // Bare eight-byte reply: no timestamp words, so the send time reads as
    // zero. Twenty seconds is above the ten-second reset minimum, which must
    // therefore still show as the minimum.
    send_echo(8'h00, 16'h0, 16'd0, 32'h0, 32'h0, 4, 1'b0, 32'd20, 20'd5);
    // Receive time earlier than the send time clamps the round trip to zero.
    send_echo(8'h00, 16'h0, 16'd1, 32'd100, 32'd999999, 12, 1'b0, 32'd100, 20'd0);
    // Echo request and a type with every bit set are not replies.
    send_echo(8'h08, 16'h0, 16'd2, 32'h0, 32'h0, 10, 1'b0, 32'h0, 20'h0);
    send_echo(8'hff, 16'h0, 16'd2, 32'h0, 32'h0, 10, 1'b0, 32'h0, 20'h0);
    // Same sequence as the newest one is a duplicate.
    send_echo(8'h00, 16'h0, 16'd1, 32'h0, 32'h0, 10, 1'b0, 32'd1, 20'h0);
    // A bad checksum still advances the newest sequence, so the clean copy
    // that follows is a duplicate.
    make_echo(8'h00, 16'h0, 16'd5, 32'd7, 32'd10, 10, 1'b0);
    pkt_words[1] ^= 16'h0100;
    drive_packet(32'd7, 20'd20);
    send_echo(8'h00, 16'h0, 16'd5, 32'd7, 32'd10, 10, 1'b0, 32'd7, 20'd20);
    // Eleven bytes: the seconds are present, the microseconds are not.
    send_echo(8'h00, 16'h0, 16'd6, 32'h1234_5678, 32'h0, 6, 1'b1,
              32'h1234_5679, 20'd999999);
    // Longer than the packet limit: the tail is neither summed nor captured.
    send_echo(8'h00, 16'h0, 16'd7, 32'd50, 32'd3, 520, 1'b0, 32'd52, 20'd1);
    // All-ones words.
    make_echo(8'hff, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 10, 1'b0);
    foreach (pkt_words[i]) pkt_words[i] = 16'hffff;
    drive_packet(32'hffff_ffff, 20'd999999);
    // Send microseconds far beyond one second in the timestamp words.
    send_echo(8'h00, 16'h0, 16'd8, 32'hffff_ffff, 32'hffff_ffff, 10, 1'b0, 32'h0, 20'd999999);
    // With the check off a foreign identifier is still a good reply.
    send_echo(8'h00, 16'h1234, 16'd9, 32'd1, 32'd0, 10, 1'b0, 32'd1, 20'd250);
  endtask

  // Identifier check on, at the top identifier; writes to the spare indexes
  // must change nothing.
  task automatic test_id_check();
    settle();
    write_reg(icerc_pkg::REG_OWN_ID, 16'hffff);
    write_reg(icerc_pkg::REG_ID_CHECK_ON, 16'h0001);
    send_echo(8'h00, 16'hffff, m_newest_seq + 16'd1, 32'd9, 32'd0, 10, 1'b0, 32'd9, 20'd77);
    send_echo(8'h00, 16'h0000, m_newest_seq + 16'd1, 32'd9, 32'd0, 10, 1'b0, 32'd9, 20'd77);
    send_echo(8'h00, 16'hfffe, m_newest_seq + 16'd1, 32'd9, 32'd0, 10, 1'b0, 32'd9, 20'd77);
    settle();
    write_reg(REG_SPARE_A, 16'h0000);
    write_reg(REG_SPARE_B, 16'hfffe);
    send_echo(8'h00, 16'hffff, m_newest_seq + 16'd1, 32'd9, 32'd0, 10, 1'b0, 32'd9, 20'd78);
    settle();
    write_reg(icerc_pkg::REG_ID_CHECK_ON, 16'hfffe);
  endtask

  // Random traffic for one idling phase and one register setting. Most
  // packets are well-formed replies with random content; the rest break one
  // rule each or are plain noise.
  task automatic run_random_phase(input int unsigned idle_pct, stall_pct,
                                  input logic [15:0] own, input bit check_on,
                                  input int unsigned beat_goal);
    int unsigned start;
    int unsigned kind;
    int unsigned len_pick;
    int          nwords;
    bit          odd;
    bit          paused;
    logic [7:0]  typ;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] ssec;
    logic [31:0] susec;
    logic [31:0] rsec;
    logic [19:0] rusec;

    settle();
    write_reg(icerc_pkg::REG_OWN_ID, own);
    write_reg(icerc_pkg::REG_ID_CHECK_ON, {15'($urandom), check_on});
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start  = beats_sent;
    paused = 1'b0;
    while (beats_sent - start < beat_goal) begin
      len_pick = $urandom_range(79);
      if (len_pick == 0) nwords = $urandom_range(500, 560);
      else if (len_pick <= 4) nwords = $urandom_range(1, 4);
      else nwords = $urandom_range(4, 16);
      odd   = ($urandom_range(3) == 0);
      typ   = 8'h00;
      ident = m_id_check ? m_own_id : 16'($urandom);
      seq   = m_newest_seq + 16'($urandom_range(1, 3));
      ssec  = $urandom;
      susec = $urandom_range(999999);
      rsec  = ssec + $urandom_range(0, 3);
      rusec = 20'($urandom_range(999999));

      kind = $urandom_range(99);
      if (kind >= 70 && kind < 75) typ = 8'($urandom_range(1, 255));
      else if (kind >= 75 && kind < 80) ident = m_own_id ^ 16'($urandom_range(1, 65535));
      else if (kind >= 80 && kind < 87) seq = m_newest_seq - 16'($urandom_range(0, 5));
      else if (kind >= 94 && kind < 97) begin
        ssec  = $urandom;
        susec = $urandom;
        rsec  = $urandom;
      end

      make_echo(typ, ident, seq, ssec, susec, nwords, odd);
      if (kind >= 87 && kind < 94 && nwords > 1) pkt_words[1] ^= 16'(1) << $urandom_range(15);
      if (kind >= 97) foreach (pkt_words[i]) pkt_words[i] = 16'($urandom);
      drive_packet(rsec, rusec);

      // Halfway through, hold the packet side until the block has drained.
      if (!paused && beats_sent - start >= beat_goal / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  // Round trips at the top of their range overflow the sum of squares,
  // which must then stick at its ceiling.
  task automatic test_saturation();
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(icerc_pkg::REG_ID_CHECK_ON, 16'h0000);
    repeat (3) begin
      send_echo(8'h00, 16'h0, m_newest_seq + 16'd1, 32'h0, 32'h0, 4, 1'b0,
                32'hffff_ffff, 20'd999999);
    end
  endtask

  // The highest sequence number: once seen, nothing can be newer, so even a
  // wrapped sequence of zero is refused.
  task automatic test_sequence_top();
    send_echo(8'h00, 16'h0, 16'hffff, 32'd11, 32'd0, 10, 1'b0, 32'd11, 20'd9);
    send_echo(8'h00, 16'h0, 16'hffff, 32'd11, 32'd0, 10, 1'b0, 32'd11, 20'd9);
    send_echo(8'h00, 16'h0, 16'h0000, 32'd11, 32'd0, 10, 1'b0, 32'd11, 20'd9);
  endtask

  // --------------------------------------------------------------------------
  // Run.
  // --------------------------------------------------------------------------
  initial begin
    // Every input is known from time zero.
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_index    = icerc_pkg::REG_OWN_ID;
    cfg_wr_data     = 16'h0000;
    in_ch.valid     = 1'b0;
    in_ch.word      = 16'h0000;
    in_ch.last      = 1'b0;
    in_ch.odd_byte  = 1'b0;
    in_ch.recv_sec  = 32'h0;
    in_ch.recv_usec = 20'h0;
    out_ch.ready    = 1'b1;

    // Shadow state as the block holds it after reset.
    m_own_id     = 16'h0000;
    m_id_check   = 1'b0;
    m_word_idx   = 16'h0000;
    m_sum        = 16'h0000;
    m_type       = 8'h00;
    m_ident      = 16'h0000;
    m_seq        = 16'h0000;
    m_send_sec   = 32'h0;
    m_send_usec  = 32'h0;
    m_seq_seen   = 1'b0;
    m_newest_seq = 16'h0000;
    m_min        = icerc_pkg::MIN_RESET_US;
    m_max        = 32'h0;
    m_total      = 48'h0;
    m_sq_total   = 64'h0;
    m_count      = 32'h0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_verdicts();
    test_id_check();
    run_random_phase(0, 0, 16'h0000, 1'b1, 285);
    run_random_phase(87, 0, 16'hffff, 1'b1, 285);
    run_random_phase(0, 87, 16'($urandom), 1'b0, 285);
    run_random_phase(9, 9, 16'($urandom), 1'b1, 285);
    test_saturation();
    test_sequence_top();

    // Drain, then give any stray result time to show up.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
